// File: hw/rtl/irc_pkg.sv
// Package for the IPv4 route cache: word types, outcome codes, FSM states
// and address helper functions. No dependencies.
package irc_pkg;

  localparam int unsigned TableEntriesDef = 128;

  typedef enum logic [2:0] {
    OUT_DIRECT  = 3'd0,
    OUT_HOST    = 3'd1,
    OUT_NET     = 3'd2,
    OUT_DEFAULT = 3'd3,
    OUT_ADDED   = 3'd4,
    OUT_DEFSET  = 3'd5,
    OUT_IGNORED = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    CFG_IFACE_UP   = 2'd0,
    CFG_IFACE_ADDR = 2'd1,
    CFG_IFACE_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_ADD_WR,
    ST_LK_RD,
    ST_LK_CHK,
    ST_LK_NEXT,
    ST_LK_DEF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        command;
    logic [31:0] dst_addr;
    logic [31:0] gate_addr;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_hop;
    logic [2:0]  outcome;
    logic        iface_found;
  } out_word_t;

  function automatic logic [31:0] class_mask(input logic [31:0] x);
    logic [31:0] m;
    if (x[31:29] == 3'b110) m = 32'hFFFF_FF00;
    else if (x[31:30] == 2'b10) m = 32'hFFFF_0000;
    else m = 32'hFF00_0000;
    return m;
  endfunction

  function automatic logic [31:0] net_of(input logic [31:0] x, input logic up,
                                         input logic [31:0] ia, input logic [31:0] im);
    logic [31:0] m;
    logic [31:0] r;
    m = class_mask(x);
    r = x & m;
    if (up && ((x & m) == (ia & m)) && (im != 32'd0)) r = x & im;
    return r;
  endfunction

endpackage

// File: hw/rtl/ip_route_cache_lru.sv
// Top level of the IPv4 route cache with LRU replacement.
// Depends on irc_pkg for word types, codes and address helpers.
//
// One command word is accepted when start_i is high and busy_o is low, and
// produces exactly one result word, shown for one cycle with done_o high;
// the receiver cannot stall it. The table lives in one synchronous memory
// (dest, gateway, stamp per slot) with a registered read port; each probe
// step is a read state followed by a check state. An add probes until it
// finds a free or matching slot or has probed every slot, then writes; a
// lookup probes with the host key, then moves on to the network key, and
// falls back to the default gateway when neither key hits. Direct lookups
// and default-gateway or ignored adds skip the table. The result word is
// shown in the cycle in which busy_o has gone low again. After reset a
// clearing pass writes zero to every slot with busy_o high; configuration
// writes are taken at any time.
module ip_route_cache_lru #(
  parameter int unsigned TABLE_ENTRIES = irc_pkg::TableEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  irc_pkg::in_word_t  in_word_i,
  output logic               busy_o,
  output logic               done_o,
  output irc_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import irc_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_ENTRIES - 1);

  // Configuration registers.
  logic        up_q;
  logic [31:0] ia_q, im_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= 1'b0;
      ia_q <= '0;
      im_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IFACE_UP:   up_q <= cfg_data_i[0];
        CFG_IFACE_ADDR: ia_q <= cfg_data_i;
        CFG_IFACE_MASK: im_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table memory: {dest, gateway, stamp}.
  logic [95:0]   mem [TABLE_ENTRIES];
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [95:0]   wdata, rdata_q;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end
  wire [31:0] r_dest  = rdata_q[95:64];
  wire [31:0] r_gate  = rdata_q[63:32];
  wire [31:0] r_stamp = rdata_q[31:0];

  function automatic logic [IW-1:0] slot_of(input logic [31:0] x);
    logic [31:0] s;
    s = x + (x >> 8);
    return IW'(s % TABLE_ENTRIES);
  endfunction

  state_e        st_q, st_d;
  in_word_t      cmd_q;
  logic [31:0]   key_q, key_d, gate_q;
  logic [IW-1:0] idx_q, idx_d, vic_q, vic_d;
  logic [31:0]   vstamp_q, vstamp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          netpass_q, netpass_d;
  out_word_t     res_q, res_d;
  logic          done_q, done_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [31:0]   dgw_q, dgw_d;

  wire  [31:0] net_ia  = net_of(ia_q, up_q, ia_q, im_q);
  wire  [31:0] dst_net = net_of(cmd_q.dst_addr, up_q, ia_q, im_q);
  wire  [31:0] gw_net  = net_of(r_gate, up_q, ia_q, im_q);
  wire  [31:0] dg_net  = net_of(dgw_q, up_q, ia_q, im_q);
  wire  [IW-1:0] idx_nx = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
  wire  last_probe = (cnt_q == CW'(TABLE_ENTRIES - 1));

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR:   if (clr_q == LastIdx) st_d = ST_IDLE;
      ST_IDLE: begin
        if (start_i) begin
          if (!in_word_i.command) begin
            if (in_word_i.dst_addr == 32'd0) st_d = ST_DONE;
            else if (in_word_i.gate_addr != 0 && up_q && ia_q == in_word_i.dst_addr)
              st_d = ST_DONE;
            else st_d = ST_ADD_RD;
          end else begin
            st_d = ST_LK_RD;
          end
        end
      end
      ST_ADD_RD:  st_d = ST_ADD_CHK;
      ST_ADD_CHK: begin
        if (r_dest == 0 || r_dest == cmd_q.dst_addr || last_probe) st_d = ST_ADD_WR;
        else st_d = ST_ADD_RD;
      end
      ST_ADD_WR:  st_d = ST_IDLE;
      ST_LK_RD:   st_d = ST_LK_CHK;
      ST_LK_CHK: begin
        if (r_dest == key_q && r_dest != r_gate) st_d = ST_IDLE;
        else if (r_dest == 0 || last_probe) st_d = netpass_q ? ST_LK_DEF : ST_LK_NEXT;
        else st_d = ST_LK_RD;
      end
      ST_LK_NEXT: st_d = ST_LK_RD;
      ST_LK_DEF:  st_d = ST_IDLE;
      ST_DONE:    st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
    // A lookup served by the interface goes straight to the result.
    if (st_q == ST_IDLE && start_i && in_word_i.command &&
        up_q && net_of(in_word_i.dst_addr, up_q, ia_q, im_q) == net_ia)
      st_d = ST_DONE;
  end

  // Datapath and outputs.
  always_comb begin
    key_d = key_q; idx_d = idx_q; vic_d = vic_q; vstamp_d = vstamp_q;
    cnt_d = cnt_q; netpass_d = netpass_q; res_d = res_q; done_d = 1'b0;
    clr_d = clr_q; dgw_d = dgw_q;
    we = 1'b0; waddr = idx_q; wdata = '0; raddr = idx_q;
    unique case (st_q)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q; clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        key_d = in_word_i.dst_addr;
        idx_d = slot_of(in_word_i.dst_addr);
        vic_d = idx_d;
        cnt_d = '0;
        netpass_d = 1'b0;
        res_d = '0;
        if (start_i && !in_word_i.command) begin
          if (in_word_i.dst_addr == 0) begin
            dgw_d = in_word_i.gate_addr;
            res_d.outcome = OUT_DEFSET;
          end else begin
            res_d.outcome = OUT_IGNORED;
          end
        end else if (start_i) begin
          res_d.next_hop = in_word_i.dst_addr;
          res_d.outcome = OUT_DIRECT;
          res_d.iface_found = 1'b1;
        end
      end
      ST_ADD_CHK: begin
        if (r_dest == 0 || r_dest == cmd_q.dst_addr) begin
          vic_d = idx_q;
        end else begin
          if (cnt_q == 0 || r_stamp < vstamp_q) begin
            vic_d = idx_q; vstamp_d = r_stamp;
          end
          idx_d = idx_nx; cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ADD_WR: begin
        we = 1'b1; waddr = vic_q;
        wdata = {cmd_q.dst_addr, gate_q, cmd_q.now};
        done_d = 1'b1;
        res_d = '0; res_d.outcome = OUT_ADDED;
      end
      ST_LK_CHK: begin
        if (r_dest == key_q && r_dest != r_gate) begin
          we = 1'b1; waddr = idx_q;
          wdata = {r_dest, r_gate, cmd_q.now};
          done_d = 1'b1;
          res_d.next_hop = r_gate;
          res_d.outcome = netpass_q ? OUT_NET : OUT_HOST;
          res_d.iface_found = up_q && gw_net == net_ia;
        end else begin
          idx_d = idx_nx; cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LK_NEXT: begin
        key_d = dst_net; idx_d = slot_of(dst_net);
        cnt_d = '0; netpass_d = 1'b1;
      end
      ST_LK_DEF: begin
        done_d = 1'b1;
        res_d.next_hop = (dgw_q != dg_net) ? dgw_q : cmd_q.dst_addr;
        res_d.outcome = OUT_DEFAULT;
        res_d.iface_found = up_q && dg_net == net_ia;
      end
      ST_DONE: done_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; clr_q <= '0; done_q <= 1'b0; dgw_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; done_q <= done_d; dgw_q <= dgw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; idx_q <= idx_d; vic_q <= vic_d; vstamp_q <= vstamp_d;
    cnt_q <= cnt_d; netpass_q <= netpass_d; res_q <= res_d;
    if (st_q == ST_IDLE && start_i) begin
      cmd_q  <= in_word_i;
      gate_q <= (in_word_i.gate_addr == 0) ? in_word_i.dst_addr : in_word_i.gate_addr;
    end
  end

  assign busy_o     = (st_q != ST_IDLE);
  assign done_o     = done_q;
  assign out_word_o = res_q;

  // A result appears only after the block has been busy.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without work");
  // Stores happen only in the clear pass or at a final add or hit.
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (st_q == ST_CLEAR || st_q == ST_ADD_WR || st_q == ST_LK_CHK))
    else $error("unexpected memory write");
  // An add result always carries a zero next hop and no interface flag.
  a_add_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_word_o.outcome >= OUT_ADDED) |->
    (out_word_o.next_hop == 0 && !out_word_o.iface_found))
    else $error("add result with next hop");
endmodule
